// File: src/rdts_pkg.sv
// Shared types and constants for the radio dial tuning stepper.
package rdts_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] dial_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        dial_khz;
    logic [16:0]        chip_khz;
    logic signed [11:0] fine_offset_hz;
    logic [11:0]        beat_hz;
    logic [29:0]        display_hz;
  } out_word_t;

  typedef struct packed {
    logic [2:0]        demod_mode;
    logic [15:0]       band_min;
    logic [15:0]       band_max;
    logic [9:0]        band_step;
    logic [9:0]        lsb_offset;
    logic [11:0]       default_bfo;
    logic signed [9:0] bfo_trim;
  } cfg_t;

  localparam logic [1:0] CMD_UP   = 2'd0;
  localparam logic [1:0] CMD_DOWN = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  localparam logic [2:0] MODE_FM  = 3'd0;
  localparam logic [2:0] MODE_LSB = 3'd4;
  localparam logic [2:0] MODE_USB = 3'd5;
  localparam logic [2:0] MODE_CW  = 3'd6;

  localparam logic [2:0] CFG_DEMOD_MODE  = 3'd0;
  localparam logic [2:0] CFG_BAND_MIN    = 3'd1;
  localparam logic [2:0] CFG_BAND_MAX    = 3'd2;
  localparam logic [2:0] CFG_BAND_STEP   = 3'd3;
  localparam logic [2:0] CFG_LSB_OFFSET  = 3'd4;
  localparam logic [2:0] CFG_DEFAULT_BFO = 3'd5;
  localparam logic [2:0] CFG_BFO_TRIM    = 3'd6;

  localparam cfg_t CFG_RESET = '{
    demod_mode:  3'd0,
    band_min:    16'd6400,
    band_max:    16'd10800,
    band_step:   10'd10,
    lsb_offset:  10'd0,
    default_bfo: 12'd1500,
    bfo_trim:    10'sd0
  };

  localparam logic [15:0] DIAL_RESET  = 16'd9730;
  localparam int          BEAT_LOW    = 100;
  localparam int          BEAT_HIGH   = 4000;
  localparam int          HZ_PER_KHZ  = 1000;
  localparam int          FM_UNIT_HZ  = 10000;
  localparam logic [29:0] DISPLAY_TOP = 30'd655350000;

endpackage

// File: src/radio_dial_tuning_stepper_top.sv
// Top level of the radio dial tuning stepper with config registers and output skid.
//
// Usage:
//   Input channel: in_word_i carries a command (step up, step down, set dial)
//   and a requested dial value; a word is taken when in_valid_i is high and
//   in_stall_o is low. Each accepted word yields exactly one result word on
//   out_word_o, taken when out_valid_o is high and out_stall_i is low.
//   Config channel: cfg_index_i selects the register, cfg_data_i holds the
//   value; cfg_ready_o is always high. Write only while no word is in flight.
// Timing:
//   Results are registered (skid register on a stall). One word per cycle is
//   sustained while out_stall_i is low; the dial and fine offset update in a
//   single pass through the step logic into the state and result registers.
// Stall:
//   A stalled result holds in the output register; one more word is caught
//   in the skid register, and in_stall_o rises only while that is full.
// Reset:
//   Config registers return to their defaults, dial to 9730 and fine offset to zero;
//   both output slots are emptied.
module radio_dial_tuning_stepper_top import rdts_pkg::*; #(
  parameter int FINE_STEP_HZ   = 100,
  parameter int FINE_WINDOW_HZ = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t               cfg_q;
  logic [15:0]        dial_q;
  logic signed [11:0] fine_q;
  logic [15:0]        dial_d;
  logic signed [11:0] fine_d;
  out_word_t          result_d;
  out_word_t          out_q;
  out_word_t          skid_q;
  logic               out_valid_q;
  logic               skid_valid_q;
  logic               accept;
  logic               out_fire;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  rdts_step #(
    .FINE_STEP_HZ  (FINE_STEP_HZ),
    .FINE_WINDOW_HZ(FINE_WINDOW_HZ)
  ) u_step (
    .cfg_i   (cfg_q),
    .dial_i  (dial_q),
    .fine_i  (fine_q),
    .word_i  (in_word_i),
    .dial_o  (dial_d),
    .fine_o  (fine_d),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CFG_RESET;
      dial_q <= DIAL_RESET;
      fine_q <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_i)
          CFG_DEMOD_MODE: begin
            cfg_q.demod_mode <= cfg_data_i[2:0];
            fine_q           <= '0;
          end
          CFG_BAND_MIN:    cfg_q.band_min    <= cfg_data_i;
          CFG_BAND_MAX:    cfg_q.band_max    <= cfg_data_i;
          CFG_BAND_STEP:   cfg_q.band_step   <= cfg_data_i[9:0];
          CFG_LSB_OFFSET:  cfg_q.lsb_offset  <= cfg_data_i[9:0];
          CFG_DEFAULT_BFO: cfg_q.default_bfo <= cfg_data_i[11:0];
          CFG_BFO_TRIM:    cfg_q.bfo_trim    <= cfg_data_i[9:0];
          default: begin
          end
        endcase
      end else if (accept) begin
        dial_q <= dial_d;
        fine_q <= fine_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= accept;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      if (accept) begin
        out_q <= result_d;
      end
    end else if (accept) begin
      skid_q <= result_d;
    end
  end

endmodule

// File: src/rdts_step.sv
// Next dial and fine offset state plus the result word for one command.
module rdts_step import rdts_pkg::*; #(
  parameter int FINE_STEP_HZ   = 100,
  parameter int FINE_WINDOW_HZ = 1000
) (
  input  cfg_t               cfg_i,
  input  logic [15:0]        dial_i,
  input  logic signed [11:0] fine_i,
  input  in_word_t           word_i,
  output logic [15:0]        dial_o,
  output logic signed [11:0] fine_o,
  output out_word_t          result_o
);

  localparam logic signed [13:0] StepHz  = 14'(FINE_STEP_HZ);
  localparam logic signed [13:0] WinHz   = 14'(FINE_WINDOW_HZ);
  localparam logic signed [13:0] KhzHz   = 14'(HZ_PER_KHZ);
  localparam logic signed [13:0] FineMax = 14'sd2047;
  localparam logic signed [13:0] FineMin = -14'sd2048;
  localparam logic signed [13:0] BeatLo  = 14'(BEAT_LOW);
  localparam logic signed [13:0] BeatHi  = 14'(BEAT_HIGH);

  function automatic logic [15:0] clamp_band(input logic [15:0] f, input logic [15:0] lo,
                                             input logic [15:0] hi);
    logic [15:0] r;
    if (f < lo) r = lo;
    else if (f > hi) r = hi;
    else r = f;
    return r;
  endfunction

  logic               sideband;
  logic signed [13:0] fine_ext;
  logic [16:0]        dial_inc;
  logic signed [17:0] dial_dec;
  logic [16:0]        up_sum;
  logic signed [17:0] dn_diff;
  logic [15:0]        coarse_f;
  logic signed [13:0] fine_f;
  logic signed [13:0] beat_sum;
  logic [25:0]        prod_k;
  logic [29:0]        prod_fm;
  logic signed [27:0] disp_sb;

  always_comb begin
    sideband = (cfg_i.demod_mode == MODE_LSB) || (cfg_i.demod_mode == MODE_USB) ||
               (cfg_i.demod_mode == MODE_CW);
    fine_ext = {{2{fine_i[11]}}, fine_i};
    dial_inc = {1'b0, dial_i} + 17'd1;
    dial_dec = $signed({2'b00, dial_i}) - 18'sd1;
    up_sum   = {1'b0, dial_i} + {7'd0, cfg_i.band_step};
    dn_diff  = $signed({2'b00, dial_i}) - $signed({8'd0, cfg_i.band_step});
    coarse_f = dial_i;
    fine_f   = fine_ext;
    dial_o   = dial_i;
    fine_o   = fine_i;

    case (word_i.command) inside
      CMD_SET: begin
        dial_o = clamp_band(word_i.dial_value, cfg_i.band_min, cfg_i.band_max);
        fine_o = '0;
      end
      CMD_UP, CMD_DOWN: begin
        if (sideband) begin
          if (word_i.command == CMD_UP) begin
            fine_f = fine_ext + StepHz;
            if (fine_f > WinHz) begin
              if (dial_inc <= {1'b0, cfg_i.band_max}) begin
                dial_o = dial_inc[15:0];
                fine_f = fine_f - KhzHz;
              end else begin
                fine_f = WinHz;
              end
            end
          end else begin
            fine_f = fine_ext - StepHz;
            if (fine_f < -WinHz) begin
              if (dial_dec >= $signed({2'b00, cfg_i.band_min})) begin
                dial_o = dial_dec[15:0];
                fine_f = fine_f + KhzHz;
              end else begin
                fine_f = -WinHz;
              end
            end
          end
          if (fine_f > FineMax) fine_o = FineMax[11:0];
          else if (fine_f < FineMin) fine_o = FineMin[11:0];
          else fine_o = fine_f[11:0];
        end else begin
          if (word_i.command == CMD_UP) begin
            if (up_sum > {1'b0, cfg_i.band_max}) coarse_f = cfg_i.band_min;
            else coarse_f = up_sum[15:0];
          end else begin
            if (dn_diff < $signed({2'b00, cfg_i.band_min})) coarse_f = cfg_i.band_max;
            else coarse_f = dn_diff[15:0];
          end
          dial_o = clamp_band(coarse_f, cfg_i.band_min, cfg_i.band_max);
          fine_o = '0;
        end
      end
      default: begin
        dial_o = dial_i;
        fine_o = fine_i;
      end
    endcase
  end

  always_comb begin
    result_o.dial_khz       = dial_o;
    result_o.fine_offset_hz = fine_o;
    result_o.chip_khz       = {1'b0, dial_o} +
                              ((cfg_i.demod_mode == MODE_LSB) ? {7'd0, cfg_i.lsb_offset} : 17'd0);

    beat_sum = $signed({2'b00, cfg_i.default_bfo}) + {{4{cfg_i.bfo_trim[9]}}, cfg_i.bfo_trim} +
               {{2{fine_o[11]}}, fine_o};
    if (beat_sum < BeatLo) result_o.beat_hz = BeatLo[11:0];
    else if (beat_sum > BeatHi) result_o.beat_hz = BeatHi[11:0];
    else result_o.beat_hz = beat_sum[11:0];

    prod_k  = 26'(dial_o) * 26'(HZ_PER_KHZ);
    prod_fm = 30'(dial_o) * 30'(FM_UNIT_HZ);
    disp_sb = $signed({2'b00, prod_k}) + {{16{fine_o[11]}}, fine_o};

    if (sideband) begin
      if (disp_sb < 28'sd0) result_o.display_hz = '0;
      else result_o.display_hz = {2'b00, disp_sb[27:0]};
    end else if (cfg_i.demod_mode == MODE_FM) begin
      result_o.display_hz = (prod_fm > DISPLAY_TOP) ? DISPLAY_TOP : prod_fm;
    end else begin
      result_o.display_hz = {4'd0, prod_k};
    end
  end

endmodule

// File: src/rdts_checker.sv
// Port-level checks for the radio dial tuning stepper, bound to the top level.
module rdts_checker import rdts_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.beat_hz >= 12'(BEAT_LOW)) &&
                    (out_word_o.beat_hz <= 12'(BEAT_HIGH)))
    else $error("beat frequency outside clamp range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.chip_khz >= {1'b0, out_word_o.dial_khz}) &&
                    (out_word_o.display_hz <= DISPLAY_TOP))
    else $error("chip or display frequency inconsistent with dial");

endmodule

bind radio_dial_tuning_stepper_top rdts_checker u_rdts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);
